// ----- rtl/core/oga_pkg.sv -----
// ----------------------------------------------------------------------------
// oga_pkg
// Shared types, codes and helpers for the output layer gradient accumulator.
// ----------------------------------------------------------------------------
package oga_pkg;

    // fixed field widths
    localparam int NEURON_W   = 4;
    localparam int SLOT_IDX_W = 5;
    localparam int SLOT_W     = 6;   // wide enough for every weight count in range
    localparam int Q_W        = 16;
    localparam int VALUE_W    = 32;

    // function codes carried on s_tuser
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_STEP = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ACT_MODE  = 2'd0;
    localparam logic [1:0] CFG_COST_MODE = 2'd1;
    localparam logic [1:0] CFG_BIAS_EN   = 2'd2;
    localparam logic [1:0] CFG_WEIGHTS   = 2'd3;

    // activation and cost codes
    localparam logic [1:0] ACT_LINEAR   = 2'd0;
    localparam logic [1:0] ACT_RELU     = 2'd1;
    localparam logic [1:0] ACT_LOGISTIC = 2'd2;
    localparam logic       COST_QUAD    = 1'b0;

    // saturation bounds for 32-bit results, held at product width
    localparam logic signed [47:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] SAT_MIN = 48'shFFFF_8000_0000;

    // fraction bits of Q.12 products
    localparam int FRAC_BITS = 12;

    // result kind carried on m_tuser
    typedef enum logic [1:0] {
        KIND_DELTA = 2'd0,
        KIND_GRAD  = 2'd1,
        KIND_SUM   = 2'd2
    } kind_t;

    // one pipeline slot issued by the sequencer
    typedef struct packed {
        logic                valid;
        kind_t               kind;
        logic [NEURON_W-1:0] neuron;
        logic [SLOT_W-1:0]   slot;
        logic                last;
        logic                bias;
        logic                first;
    } issue_t;

    // clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/oga_delta.sv -----
// ----------------------------------------------------------------------------
// oga_delta
// Delta unit: difference, derivative product and final rounding, each registered.
// ----------------------------------------------------------------------------
module oga_delta (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] output_value,
    input  logic signed [15:0] target_value,
    input  logic signed [15:0] preact_value,
    input  logic [1:0]         act_mode,
    input  logic               cost_mode,
    output logic               done,
    output logic signed [31:0] delta
);

    logic               v1_reg, v2_reg, done_reg;
    logic               zero1_reg, zero2_reg, deriv1_reg, deriv2_reg;
    logic signed [16:0] d1_reg, d2_reg;
    logic signed [32:0] p1_reg;
    logic signed [38:0] p2_reg;
    logic signed [31:0] delta_reg;

    logic signed [16:0] one_minus_o;
    logic signed [33:0] r1_full;
    logic signed [21:0] r1;
    logic signed [39:0] r2_full;
    logic signed [31:0] delta_next;

    // out * (1 - out) operand and its rounding back to Q.12
    assign one_minus_o = 17'sd4096 - 17'(output_value);
    assign r1_full     = (34'(p1_reg) + 34'sd2048) >>> oga_pkg::FRAC_BITS;
    assign r1          = r1_full[21:0];
    assign r2_full     = (40'(p2_reg) + 40'sd2048) >>> oga_pkg::FRAC_BITS;

    // pick the delta form
    always_comb begin
        if (zero2_reg) begin
            delta_next = '0;
        end else if (deriv2_reg) begin
            delta_next = r2_full[31:0];
        end else begin
            delta_next = 32'(d2_reg);
        end
    end

    // control pulses
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // datapath, at most one multiply per stage
    always_ff @(posedge aclk) begin
        if (start) begin
            d1_reg     <= 17'(output_value) - 17'(target_value);
            p1_reg     <= 33'(output_value) * 33'(one_minus_o);
            zero1_reg  <= (act_mode == oga_pkg::ACT_RELU) && (preact_value <= 16'sd0);
            deriv1_reg <= (cost_mode == oga_pkg::COST_QUAD) &&
                          (act_mode == oga_pkg::ACT_LOGISTIC);
        end
        if (v1_reg) begin
            d2_reg     <= d1_reg;
            p2_reg     <= 39'(d1_reg) * 39'(r1);
            zero2_reg  <= zero1_reg;
            deriv2_reg <= deriv1_reg;
        end
        if (v2_reg) begin
            delta_reg <= delta_next;
        end
    end

    assign done  = done_reg;
    assign delta = delta_reg;

endmodule

// ----- rtl/core/oga_accum.sv -----
// ----------------------------------------------------------------------------
// oga_accum
// Activation and sum memories with a read, multiply, accumulate and write
// back pipeline feeding the result register.
// ----------------------------------------------------------------------------
module oga_accum #(
    parameter int MAX_NEURONS = 16,
    parameter int MAX_WEIGHTS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  oga_pkg::issue_t                     issue,
    input  logic signed [31:0]                  delta,
    input  logic                                act_wr_en,
    input  logic [oga_pkg::SLOT_IDX_W-1:0]      act_wr_addr,
    input  logic signed [15:0]                  act_wr_data,
    output logic                                advance,
    output logic                                busy,
    output logic                                res_valid,
    input  logic                                res_ready,
    output oga_pkg::kind_t                      res_kind,
    output logic [oga_pkg::NEURON_W-1:0]        res_neuron,
    output logic [oga_pkg::SLOT_IDX_W-1:0]      res_slot,
    output logic signed [31:0]                  res_value,
    output logic                                res_last
);

    localparam int AW    = $clog2(MAX_WEIGHTS);
    localparam int DEPTH = MAX_NEURONS * MAX_WEIGHTS;
    localparam int IW    = $clog2(DEPTH);

    logic signed [15:0] act_mem [MAX_WEIGHTS];
    logic signed [31:0] sum_mem [DEPTH];

    oga_pkg::issue_t    c1_reg, c2_reg;
    logic signed [15:0] act_rd_reg;
    logic signed [31:0] sum_rd_reg, sum2_reg;
    logic signed [47:0] prod_reg;

    logic                               out_valid_reg;
    oga_pkg::kind_t                     out_kind_reg;
    logic [oga_pkg::NEURON_W-1:0]       out_neuron_reg;
    logic [oga_pkg::SLOT_IDX_W-1:0]     out_slot_reg;
    logic signed [31:0]                 out_value_reg;
    logic                               out_last_reg;

    logic [IW-1:0]      rd_idx, wr_idx;
    logic signed [47:0] rnd_full;
    logic signed [31:0] g_mul, g, acc, value;
    logic               sum_wr_en;

    // the whole pipeline moves only when the result register can take an item
    assign advance = !out_valid_reg || res_ready;
    assign busy    = c1_reg.valid || c2_reg.valid;

    // flat store address: neuron row, slot column
    assign rd_idx = IW'(issue.neuron) * IW'(MAX_WEIGHTS) + IW'(issue.slot);
    assign wr_idx = IW'(c2_reg.neuron) * IW'(MAX_WEIGHTS) + IW'(c2_reg.slot);

    // last stage: round, saturate, accumulate
    assign rnd_full  = (prod_reg + 48'sd2048) >>> oga_pkg::FRAC_BITS;
    assign g_mul     = oga_pkg::sat32(rnd_full);
    assign g         = c2_reg.bias ? delta : g_mul;
    assign acc       = c2_reg.first ? g : oga_pkg::sat32(48'(sum2_reg) + 48'(g));
    assign sum_wr_en = advance && c2_reg.valid && (c2_reg.kind == oga_pkg::KIND_GRAD);

    always_comb begin
        case (c2_reg.kind)
            oga_pkg::KIND_DELTA: value = delta;
            oga_pkg::KIND_GRAD:  value = g;
            oga_pkg::KIND_SUM:   value = sum2_reg;
            default:             value = sum2_reg;
        endcase
    end

    // activation memory: load port and pipeline read port
    always_ff @(posedge aclk) begin
        if (act_wr_en) begin
            act_mem[AW'(act_wr_addr)] <= act_wr_data;
        end
        if (advance) begin
            act_rd_reg <= act_mem[AW'(issue.slot)];
        end
    end

    // sum memory: read at issue, write back from the c2 stage
    always_ff @(posedge aclk) begin
        if (sum_wr_en) begin
            sum_mem[wr_idx] <= acc;
        end
        if (advance) begin
            sum_rd_reg <= sum_mem[rd_idx];
        end
    end

    // stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
        end else if (advance) begin
            c1_reg <= issue;
            c2_reg <= c1_reg;
        end
    end

    // multiply stage
    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= 48'(delta) * 48'(act_rd_reg);
            sum2_reg <= sum_rd_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= c2_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && c2_reg.valid) begin
            out_kind_reg   <= c2_reg.kind;
            out_neuron_reg <= c2_reg.neuron;
            out_slot_reg   <= c2_reg.slot[oga_pkg::SLOT_IDX_W-1:0];
            out_value_reg  <= value;
            out_last_reg   <= c2_reg.last;
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_kind   = out_kind_reg;
    assign res_neuron = out_neuron_reg;
    assign res_slot   = out_slot_reg;
    assign res_value  = out_value_reg;
    assign res_last   = out_last_reg;

endmodule

// ----- rtl/core/output_layer_gradient_accumulate.sv -----
// ----------------------------------------------------------------------------
// output_layer_gradient_accumulate
// Output layer backpropagation: neuron delta, per-weight gradients and
// batch sums held in a per-neuron, per-slot memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    tuser func, tdata item fields
//  m_        out        m_tvalid / m_tready    tuser kind, tlast, tdata result
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  a load is written on acceptance; a read passes the issue state, pipeline stages
//  and result register; a neuron step for n used slots runs the delta unit, hands
//  over, issues the delta, then one gradient per cycle, unless m_tready stalls,
//  via the sum memory read-modify-write path; pipeline drains before the next item
//  a stalled m_tready freezes the whole pipeline; results are never dropped
//  reset clears control only; both memories are undefined until written
// ----------------------------------------------------------------------------
module output_layer_gradient_accumulate #(
    parameter int MAX_NEURONS = 16,
    parameter int MAX_WEIGHTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,    // func
    // slot_index[4:0], neuron_index[8:5], activation_in[24:9],
    // output_value[40:25], target_value[56:41], preact_value[72:57],
    // first_sample[73], zero fill[79:74]
    input  logic [79:0] s_tdata,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,    // kind
    output logic        m_tlast,    // last
    // out_neuron[3:0], out_slot[8:4], value[40:9], zero fill[47:41]
    output logic [47:0] m_tdata,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int SW = $clog2(MAX_WEIGHTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA_WAIT,
        ST_ISSUE_DELTA,
        ST_ISSUE_SLOTS,
        ST_ISSUE_READ
    } state_t;

    state_t state_reg;

    // configuration
    logic [1:0] act_mode_reg;
    logic       cost_mode_reg;
    logic       bias_en_reg;
    logic [5:0] weights_reg;

    // item fields held for the sequencer
    logic [oga_pkg::NEURON_W-1:0]   neuron_reg;
    logic [oga_pkg::SLOT_IDX_W-1:0] slot_reg;
    logic                           first_reg;
    logic [SW-1:0]                  cnt_reg;

    // unpacked input fields
    logic [oga_pkg::SLOT_IDX_W-1:0] in_slot;
    logic [oga_pkg::NEURON_W-1:0]   in_neuron;
    logic signed [15:0]             in_act, in_out, in_tgt, in_pre;
    logic                           in_first;

    logic                s_accept, slot_ok, neuron_ok;
    logic                delta_start, delta_done;
    logic signed [31:0]  delta;
    logic [5:0]          n_eff, n_last;
    logic                cnt_last;
    oga_pkg::issue_t     issue;
    logic                advance, busy;
    oga_pkg::kind_t      res_kind;
    logic [3:0]          res_neuron;
    logic [4:0]          res_slot;
    logic signed [31:0]  res_value;
    logic                res_last, res_valid;

    assign in_slot   = s_tdata[4:0];
    assign in_neuron = s_tdata[8:5];
    assign in_act    = s_tdata[24:9];
    assign in_out    = s_tdata[40:25];
    assign in_tgt    = s_tdata[56:41];
    assign in_pre    = s_tdata[72:57];
    assign in_first  = s_tdata[73];

    assign s_tready  = (state_reg == ST_IDLE) && !busy;
    assign s_accept  = s_tvalid && s_tready;
    assign slot_ok   = 32'(in_slot) < MAX_WEIGHTS;
    assign neuron_ok = 32'(in_neuron) < MAX_NEURONS;

    assign delta_start = s_accept && (s_tuser == oga_pkg::FUNC_STEP) && neuron_ok;

    // effective slot count, clamped to 1..MAX_WEIGHTS
    always_comb begin
        if (weights_reg == 6'd0) begin
            n_eff = 6'd1;
        end else if (32'(weights_reg) > MAX_WEIGHTS) begin
            n_eff = 6'(MAX_WEIGHTS);
        end else begin
            n_eff = weights_reg;
        end
    end
    assign n_last   = n_eff - 6'd1;
    assign cnt_last = 6'(cnt_reg) == n_last;

    // issue towards the memory pipeline
    always_comb begin
        issue        = '0;
        issue.neuron = neuron_reg;
        issue.first  = first_reg;
        case (state_reg)
            ST_ISSUE_DELTA: begin
                issue.valid = 1'b1;
                issue.kind  = oga_pkg::KIND_DELTA;
            end
            ST_ISSUE_SLOTS: begin
                issue.valid = 1'b1;
                issue.kind  = oga_pkg::KIND_GRAD;
                issue.slot  = 6'(cnt_reg);
                issue.last  = cnt_last;
                issue.bias  = bias_en_reg && cnt_last;
            end
            ST_ISSUE_READ: begin
                issue.valid = 1'b1;
                issue.kind  = oga_pkg::KIND_SUM;
                issue.slot  = 6'(slot_reg);
                issue.last  = 1'b1;
            end
            default: begin
                issue.valid = 1'b0;
            end
        endcase
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_mode_reg  <= oga_pkg::ACT_LINEAR;
            cost_mode_reg <= oga_pkg::COST_QUAD;
            bias_en_reg   <= 1'b0;
            weights_reg   <= 6'd32;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                oga_pkg::CFG_ACT_MODE:  act_mode_reg  <= cfg_data[1:0];
                oga_pkg::CFG_COST_MODE: cost_mode_reg <= cfg_data[0];
                oga_pkg::CFG_BIAS_EN:   bias_en_reg   <= cfg_data[0];
                oga_pkg::CFG_WEIGHTS:   weights_reg   <= cfg_data;
                default:                weights_reg   <= weights_reg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        neuron_reg <= in_neuron;
                        slot_reg   <= in_slot;
                        first_reg  <= in_first;
                        cnt_reg    <= '0;
                        if (delta_start) begin
                            state_reg <= ST_DELTA_WAIT;
                        end else if ((s_tuser == oga_pkg::FUNC_READ) && slot_ok && neuron_ok) begin
                            state_reg <= ST_ISSUE_READ;
                        end
                    end
                end
                ST_DELTA_WAIT: begin
                    if (delta_done) begin
                        state_reg <= ST_ISSUE_DELTA;
                    end
                end
                ST_ISSUE_DELTA: begin
                    if (advance) begin
                        state_reg <= ST_ISSUE_SLOTS;
                    end
                end
                ST_ISSUE_SLOTS: begin
                    if (advance) begin
                        if (cnt_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                ST_ISSUE_READ: begin
                    if (advance) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    oga_delta u_delta (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (delta_start),
        .output_value (in_out),
        .target_value (in_tgt),
        .preact_value (in_pre),
        .act_mode     (act_mode_reg),
        .cost_mode    (cost_mode_reg),
        .done         (delta_done),
        .delta        (delta)
    );

    oga_accum #(
        .MAX_NEURONS (MAX_NEURONS),
        .MAX_WEIGHTS (MAX_WEIGHTS)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue       (issue),
        .delta       (delta),
        .act_wr_en   (s_accept && (s_tuser == oga_pkg::FUNC_LOAD) && slot_ok),
        .act_wr_addr (in_slot),
        .act_wr_data (in_act),
        .advance     (advance),
        .busy        (busy),
        .res_valid   (res_valid),
        .res_ready   (m_tready),
        .res_kind    (res_kind),
        .res_neuron  (res_neuron),
        .res_slot    (res_slot),
        .res_value   (res_value),
        .res_last    (res_last)
    );

    // result packing
    assign m_tvalid = res_valid;
    assign m_tuser  = res_kind;
    assign m_tlast  = res_last;
    assign m_tdata  = {7'd0, res_value, res_slot, res_neuron};

endmodule

// ----- rtl/core/oga_checker.sv -----
// ----------------------------------------------------------------------------
// oga_checker
// Port-level checks on the result stream and its link to input acceptance.
// ----------------------------------------------------------------------------
module oga_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [1:0]  m_tuser,
    input logic        m_tlast,
    input logic [47:0] m_tdata
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // a delta always has gradients behind it, so no new item is taken
    a_delta_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == oga_pkg::KIND_DELTA) |-> !m_tlast && !s_tready)
        else $error("delta result marked last or input open");

    // a gradient that is not the last one keeps the input closed
    a_grad_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == oga_pkg::KIND_GRAD) && !m_tlast |-> !s_tready)
        else $error("input open while a step is unfinished");

    // a read returns exactly one result
    a_sum_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == oga_pkg::KIND_SUM) |-> m_tlast)
        else $error("sum result not marked last");

endmodule

bind output_layer_gradient_accumulate oga_checker u_oga_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tdata  (m_tdata)
);
